// ===== hw/rtl/nrte_pkg.sv =====
// ----------------------------------------------------------------------------
// nrte_pkg
// Shared types, character codes and helpers for the RMC time extractor.
// ----------------------------------------------------------------------------
package nrte_pkg;

  typedef enum logic [2:0] {
    ST_NOT_RMC   = 3'd0,
    ST_BAD_TIME  = 3'd1,
    ST_BAD_CSUM  = 3'd2,
    ST_NOT_VALID = 3'd3,
    ST_ACCEPTED  = 3'd4,
    ST_END_MARK  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FIX_NONE = 2'd0,
    FIX_A    = 2'd1,
    FIX_V    = 2'd2
  } fix_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;

  localparam logic [4:0] HOUR_OFFSET_RESET = 5'd8;
  localparam logic [6:0] HOURS_PER_DAY     = 7'd24;
  localparam logic [6:0] MINUTES_PER_HOUR  = 7'd60;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       token_end;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic       have_time;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } result_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = CH_DOLLAR;
      3'd1: c = CH_G;
      3'd2: c = CH_P;
      3'd3: c = CH_R;
      3'd4: c = CH_M;
      default: c = CH_C;
    endcase
    return c;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
      r = {1'b1, t[3:0]};
    end else if (c >= CH_A && c <= CH_F) begin
      t = c - CH_A + 8'd10;
      r = {1'b1, t[3:0]};
    end else if (c >= CH_LA && c <= CH_LF) begin
      t = c - CH_LA + 8'd10;
      r = {1'b1, t[3:0]};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/nmea_rmc_time_extractor.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_time_extractor
// Parses $GPRMC tokens byte by byte and reports the latest local time.
// ----------------------------------------------------------------------------
// Input channel: one byte per beat (byte_value, token_end) on in_valid /
// in_stall. token_end marks the last byte of a whitespace-delimited token.
// Output channel: one beat per token end on out_valid / out_stall, carrying
// status and the latest accepted time (have_time, out_hour/minute/second).
// Config: cfg_we writes cfg_wdata into hour_offset (reset value 8); write
// only while no beat is in flight.
// Path: an accepted byte waits in the input register; the parser state and,
// for a final byte, the result register update together when it is taken.
// Throughput: one byte per cycle unless a final byte is held; the running
// XOR and position counter update once per byte in a single register stage.
// Reset: rst (synchronous) clears all token state, the latest time and the
// stop flag, and empties both stages.
// Receiver stall: the result beat holds; a non-final byte still passes, a
// final byte waits in the input register, and in_stall rises behind it.
// ----------------------------------------------------------------------------
module nmea_rmc_time_extractor (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_value,
  input  logic       token_end,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic       have_time,
  output logic [4:0] out_hour,
  output logic [5:0] out_minute,
  output logic [5:0] out_second
);

  nrte_pkg::item_t   item_in;
  nrte_pkg::item_t   item;
  nrte_pkg::result_t res;
  nrte_pkg::result_t res_q;
  logic              advance;
  logic              res_valid;
  logic              res_taken;

  assign item_in.byte_value = byte_value;
  assign item_in.token_end  = token_end;

  nrte_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .item_in  (item_in),
    .res_busy (out_valid),
    .res_taken(res_taken),
    .advance  (advance),
    .item     (item)
  );

  nrte_token_parser u_parse (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .advance  (advance),
    .item     (item),
    .res_valid(res_valid),
    .res      (res)
  );

  nrte_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res      (res),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .res_taken(res_taken),
    .res_q    (res_q)
  );

  assign status     = res_q.status;
  assign have_time  = res_q.have_time;
  assign out_hour   = res_q.hour;
  assign out_minute = res_q.minute;
  assign out_second = res_q.second;

endmodule

// ===== hw/rtl/nrte_in_stage.sv =====
// ----------------------------------------------------------------------------
// nrte_in_stage
// Input register; feeds the parser; a final byte waits for result room.
// ----------------------------------------------------------------------------
module nrte_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  nrte_pkg::item_t item_in,
  input  logic           res_busy,
  input  logic           res_taken,
  output logic           advance,
  output nrte_pkg::item_t item
);

  logic held;
  logic held_next;

  // a byte that closes a token needs a free result slot
  assign advance  = held && (!item.token_end || !res_busy || res_taken);
  assign in_stall = held && !advance;

  always_comb begin
    held_next = held;
    if (advance) held_next = 1'b0;
    if (in_valid && !in_stall) held_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= item_in;
    end
  end

endmodule

// ===== hw/rtl/nrte_token_parser.sv =====
// ----------------------------------------------------------------------------
// nrte_token_parser
// Per-byte token state, checksum, time capture and end-of-token status.
// ----------------------------------------------------------------------------
module nrte_token_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  input  logic              advance,
  input  nrte_pkg::item_t   item,
  output logic              res_valid,
  output nrte_pkg::result_t res
);

  localparam logic [3:0] POS_FIRST  = 4'd0;
  localparam logic [3:0] POS_FIELD  = 4'd2;
  localparam logic [3:0] POS_XOR    = 4'd4;
  localparam logic [3:0] POS_HDR    = 4'd5;
  localparam logic [3:0] POS_COMMA  = 4'd6;
  localparam logic [3:0] POS_HH_T   = 4'd7;
  localparam logic [3:0] POS_HH_U   = 4'd8;
  localparam logic [3:0] POS_MM_T   = 4'd9;
  localparam logic [3:0] POS_MM_U   = 4'd10;
  localparam logic [3:0] POS_SS_T   = 4'd11;
  localparam logic [3:0] POS_SS_U   = 4'd12;
  localparam logic [3:0] POS_MAX    = 4'd15;
  localparam logic [5:0] TWO_DAYS   = 6'd48;

  logic [4:0]       hour_offset;
  logic [7:0]       tail_bytes [3];
  logic [3:0]       byte_position;
  logic             header_match;
  logic             time_fault;
  logic [4:0]       cand_hour;
  logic [5:0]       cand_minute;
  logic [5:0]       cand_second;
  logic [7:0]       xor_sum;
  nrte_pkg::fix_t   fix_mark;
  logic [4:0]       latest_hour;
  logic [5:0]       latest_minute;
  logic [5:0]       latest_second;
  logic             time_seen;
  logic             stopped;

  logic [7:0]       tail_bytes_next [3];
  logic [3:0]       byte_position_next;
  logic             header_match_next;
  logic             time_fault_next;
  logic [4:0]       cand_hour_next;
  logic [5:0]       cand_minute_next;
  logic [5:0]       cand_second_next;
  logic [7:0]       xor_sum_next;
  nrte_pkg::fix_t   fix_mark_next;
  logic [4:0]       latest_hour_next;
  logic [5:0]       latest_minute_next;
  logic [5:0]       latest_second_next;
  logic             time_seen_next;
  logic             stopped_next;
  nrte_pkg::status_t status_next;

  logic [7:0] b;
  logic [3:0] p;
  logic       is_digit;
  logic [7:0] b_off;
  logic [3:0] d;
  logic [6:0] tens;
  logic [6:0] two_val;
  logic [4:0] hex_hi;
  logic [4:0] hex_lo;
  logic [5:0] hour_sum;
  logic [5:0] hour_wrap;

  assign b        = item.byte_value;
  assign p        = byte_position;
  assign is_digit = (b >= nrte_pkg::CH_0) && (b <= nrte_pkg::CH_9);
  assign b_off    = b - nrte_pkg::CH_0;
  assign d        = b_off[3:0];
  assign hex_hi   = nrte_pkg::hex_digit(tail_bytes[2]);
  assign hex_lo   = nrte_pkg::hex_digit(b);

  always_comb begin
    case (p)
      POS_HH_U: tens = {2'b00, cand_hour};
      POS_MM_U: tens = {1'b0, cand_minute};
      default:  tens = {1'b0, cand_second};
    endcase
  end

  assign two_val = {tens[3:0], 3'b000} + {tens[5:0], 1'b0} + {3'b000, d};

  always_comb begin
    tail_bytes_next    = tail_bytes;
    byte_position_next = byte_position;
    header_match_next  = header_match;
    time_fault_next    = time_fault;
    cand_hour_next     = cand_hour;
    cand_minute_next   = cand_minute;
    cand_second_next   = cand_second;
    xor_sum_next       = xor_sum;
    fix_mark_next      = fix_mark;
    latest_hour_next   = latest_hour;
    latest_minute_next = latest_minute;
    latest_second_next = latest_second;
    time_seen_next     = time_seen;
    stopped_next       = stopped;
    status_next        = nrte_pkg::ST_NOT_RMC;
    hour_sum           = {1'b0, cand_hour} + {1'b0, hour_offset};
    hour_wrap          = hour_sum;

    if (!stopped) begin
      if (p == POS_FIRST && b == nrte_pkg::CH_E) stopped_next = 1'b1;
      if (p < POS_COMMA && b != nrte_pkg::hdr_char(p[2:0])) header_match_next = 1'b0;
      if (p == POS_COMMA && b != nrte_pkg::CH_COMMA) time_fault_next = 1'b1;
      if (p >= POS_HH_T && p <= POS_SS_U) begin
        if (!is_digit) begin
          time_fault_next = 1'b1;
        end else if (!time_fault) begin
          case (p)
            POS_HH_T: cand_hour_next = {1'b0, d};
            POS_HH_U: begin
              if (two_val >= nrte_pkg::HOURS_PER_DAY) time_fault_next = 1'b1;
              cand_hour_next = two_val[4:0];
            end
            POS_MM_T: cand_minute_next = {2'b00, d};
            POS_MM_U: begin
              if (two_val >= nrte_pkg::MINUTES_PER_HOUR) time_fault_next = 1'b1;
              cand_minute_next = two_val[5:0];
            end
            POS_SS_T: cand_second_next = {2'b00, d};
            POS_SS_U: begin
              if (two_val >= nrte_pkg::MINUTES_PER_HOUR) time_fault_next = 1'b1;
              cand_second_next = two_val[5:0];
            end
            default: ;
          endcase
        end
      end
      if (p >= POS_FIELD && tail_bytes[1] == nrte_pkg::CH_COMMA
          && b == nrte_pkg::CH_COMMA) begin
        if (tail_bytes[2] == nrte_pkg::CH_V) begin
          fix_mark_next = nrte_pkg::FIX_V;
        end else if (tail_bytes[2] == nrte_pkg::CH_A && fix_mark != nrte_pkg::FIX_V) begin
          fix_mark_next = nrte_pkg::FIX_A;
        end
      end
      if (p >= POS_XOR) xor_sum_next = xor_sum ^ tail_bytes[0];
      tail_bytes_next[0] = tail_bytes[1];
      tail_bytes_next[1] = tail_bytes[2];
      tail_bytes_next[2] = b;
      if (byte_position < POS_MAX) byte_position_next = byte_position + 4'd1;
    end

    hour_sum = {1'b0, cand_hour_next} + {1'b0, hour_offset};
    if (hour_sum >= TWO_DAYS) begin
      hour_wrap = hour_sum - TWO_DAYS;
    end else if (hour_sum >= nrte_pkg::HOURS_PER_DAY[5:0]) begin
      hour_wrap = hour_sum - nrte_pkg::HOURS_PER_DAY[5:0];
    end

    if (item.token_end) begin
      if (stopped_next) begin
        status_next = nrte_pkg::ST_END_MARK;
      end else if (!header_match_next || p < POS_HDR) begin
        status_next = nrte_pkg::ST_NOT_RMC;
      end else if (time_fault_next || p < POS_SS_U) begin
        status_next = nrte_pkg::ST_BAD_TIME;
      end else if (!hex_hi[4] || !hex_lo[4] || {hex_hi[3:0], hex_lo[3:0]} != xor_sum_next) begin
        status_next = nrte_pkg::ST_BAD_CSUM;
      end else if (fix_mark_next != nrte_pkg::FIX_A) begin
        status_next = nrte_pkg::ST_NOT_VALID;
      end else begin
        status_next        = nrte_pkg::ST_ACCEPTED;
        latest_hour_next   = hour_wrap[4:0];
        latest_minute_next = cand_minute_next;
        latest_second_next = cand_second_next;
        time_seen_next     = 1'b1;
      end
      if (!stopped_next) begin
        tail_bytes_next[0] = 8'd0;
        tail_bytes_next[1] = 8'd0;
        tail_bytes_next[2] = 8'd0;
        byte_position_next = POS_FIRST;
        header_match_next  = 1'b1;
        time_fault_next    = 1'b0;
        cand_hour_next     = 5'd0;
        cand_minute_next   = 6'd0;
        cand_second_next   = 6'd0;
        xor_sum_next       = 8'd0;
        fix_mark_next      = nrte_pkg::FIX_NONE;
      end
    end
  end

  assign res_valid     = advance && item.token_end;
  assign res.status    = status_next;
  assign res.have_time = time_seen_next;
  assign res.hour      = latest_hour_next;
  assign res.minute    = latest_minute_next;
  assign res.second    = latest_second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_offset <= nrte_pkg::HOUR_OFFSET_RESET;
    end else if (cfg_we) begin
      hour_offset <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_bytes[0] <= 8'd0;
      tail_bytes[1] <= 8'd0;
      tail_bytes[2] <= 8'd0;
      byte_position <= POS_FIRST;
      header_match  <= 1'b1;
      time_fault    <= 1'b0;
      cand_hour     <= 5'd0;
      cand_minute   <= 6'd0;
      cand_second   <= 6'd0;
      xor_sum       <= 8'd0;
      fix_mark      <= nrte_pkg::FIX_NONE;
      latest_hour   <= 5'd0;
      latest_minute <= 6'd0;
      latest_second <= 6'd0;
      time_seen     <= 1'b0;
      stopped       <= 1'b0;
    end else if (advance) begin
      tail_bytes    <= tail_bytes_next;
      byte_position <= byte_position_next;
      header_match  <= header_match_next;
      time_fault    <= time_fault_next;
      cand_hour     <= cand_hour_next;
      cand_minute   <= cand_minute_next;
      cand_second   <= cand_second_next;
      xor_sum       <= xor_sum_next;
      fix_mark      <= fix_mark_next;
      latest_hour   <= latest_hour_next;
      latest_minute <= latest_minute_next;
      latest_second <= latest_second_next;
      time_seen     <= time_seen_next;
      stopped       <= stopped_next;
    end
  end

endmodule

// ===== hw/rtl/nrte_out_reg.sv =====
// ----------------------------------------------------------------------------
// nrte_out_reg
// Result register; holds a beat until the receiver takes it.
// ----------------------------------------------------------------------------
module nrte_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  nrte_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              res_taken,
  output nrte_pkg::result_t res_q
);

  logic out_valid_next;

  assign res_taken = out_valid && !out_stall;

  always_comb begin
    out_valid_next = out_valid;
    if (res_taken) out_valid_next = 1'b0;
    if (res_valid) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      res_q     <= '0;
    end else begin
      out_valid <= out_valid_next;
      if (res_valid) res_q <= res;
    end
  end

endmodule

// ===== hw/rtl/nrte_checker.sv =====
// ----------------------------------------------------------------------------
// nrte_checker
// Port-level checks on the extractor, bound to the top level.
// ----------------------------------------------------------------------------
module nrte_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status,
  input logic       have_time,
  input logic [4:0] out_hour,
  input logic [5:0] out_minute,
  input logic [5:0] out_second
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_accept_has_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == nrte_pkg::ST_ACCEPTED |-> have_time)
    else $error("accepted status without have_time");

  a_no_time_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !have_time |-> out_hour == 5'd0 && out_minute == 6'd0
                                && out_second == 6'd0)
    else $error("time reported before any accepted token");

  a_time_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(have_time) |-> have_time)
    else $error("have_time cleared without reset");

  a_end_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(status) == nrte_pkg::ST_END_MARK
    |-> status == nrte_pkg::ST_END_MARK)
    else $error("end marker status left");

endmodule

bind nmea_rmc_time_extractor nrte_checker u_chk (.*);

// ===== bench/nmea_rmc_time_extractor_test.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_time_extractor_test
// Self-checking bench for the RMC time extractor. Sentences are fed one byte
// per beat; each token end is checked against a byte-level parser kept here.
// A directed table covers every reject code and the offset extremes, then
// random RMC sentences, broken sentences and noise run under several hour
// offsets with random gaps and stalls, and the run closes with a stop marker.
// ----------------------------------------------------------------------------
module nmea_rmc_time_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {CS_NONE, CS_UPPER, CS_LOWER, CS_WRONG} cs_mode_t;

  typedef struct {
    string             body;
    cs_mode_t          cs;
    int                cfg;
    bit                lit;
    nrte_pkg::result_t want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] byte_value = 8'd0;
  logic       token_end = 1'b0;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = 5'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] status;
  logic       have_time;
  logic [4:0] out_hour;
  logic [5:0] out_minute;
  logic [5:0] out_second;

  nmea_rmc_time_extractor u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .byte_value(byte_value),
    .token_end (token_end),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .have_time (have_time),
    .out_hour  (out_hour),
    .out_minute(out_minute),
    .out_second(out_second)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser state mirrored from the block
  string          rmc_tag = "$GPRMC";
  logic [7:0]     hist [0:2];
  logic [3:0]     npos;
  bit             hdr_good;
  bit             time_bad;
  int             h_cand, m_cand, s_cand;
  logic [7:0]     run_xor;
  nrte_pkg::fix_t fix;
  logic [4:0]     t_hour;
  logic [5:0]     t_min, t_sec;
  bit             t_valid;
  bit             halted;
  int             offset_now;

  nrte_pkg::result_t status_due [$];
  logic [7:0]        tok_bytes [$];
  row_t              rows [$];

  int errors = 0;
  int cycle_count = 0;
  int src_gap_pct = 0;
  int sink_hold_pct = 0;
  int tokens_sent = 0;
  int bytes_sent = 0;
  int beats_checked = 0;
  int fixes_taken = 0;

  task automatic note_error(string msg);
    errors++;
    $display("ERROR @%0d: %s", cycle_count, msg);
  endtask

  function automatic int hex_of(logic [7:0] c);
    if (c >= nrte_pkg::CH_0 && c <= nrte_pkg::CH_9) return int'(c - nrte_pkg::CH_0);
    if (c >= nrte_pkg::CH_A && c <= nrte_pkg::CH_F) return int'(c - nrte_pkg::CH_A) + 10;
    if (c >= nrte_pkg::CH_LA && c <= nrte_pkg::CH_LF) return int'(c - nrte_pkg::CH_LA) + 10;
    return -1;
  endfunction

  function automatic void reset_sentence();
    hist[0] = 8'd0;
    hist[1] = 8'd0;
    hist[2] = 8'd0;
    npos = 4'd0;
    hdr_good = 1'b1;
    time_bad = 1'b0;
    h_cand = 0;
    m_cand = 0;
    s_cand = 0;
    run_xor = 8'd0;
    fix = nrte_pkg::FIX_NONE;
  endfunction

  function automatic int pair_value(int tens, int units, int lim);
    int v;
    v = tens * 10 + units;
    if (v >= lim) begin
      time_bad = 1'b1;
      return 0;
    end
    return v;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic is_last, output bit has,
                            output nrte_pkg::result_t r);
    logic [3:0]        p;
    int                d, hi, lo;
    nrte_pkg::status_t st;
    p = npos;
    has = 1'b0;
    r = '0;
    if (!halted) begin
      if (p == 4'd0 && b == nrte_pkg::CH_E) halted = 1'b1;
      if (p < 4'd6 && b != rmc_tag[p]) hdr_good = 1'b0;
      if (p == 4'd6 && b != nrte_pkg::CH_COMMA) time_bad = 1'b1;
      if (p >= 4'd7 && p <= 4'd12) begin
        if (b < nrte_pkg::CH_0 || b > nrte_pkg::CH_9) begin
          time_bad = 1'b1;
        end else if (!time_bad) begin
          d = int'(b - nrte_pkg::CH_0);
          case (p)
            4'd7:  h_cand = d;
            4'd8:  h_cand = pair_value(h_cand, d, nrte_pkg::HOURS_PER_DAY);
            4'd9:  m_cand = d;
            4'd10: m_cand = pair_value(m_cand, d, nrte_pkg::MINUTES_PER_HOUR);
            4'd11: s_cand = d;
            default: s_cand = pair_value(s_cand, d, nrte_pkg::MINUTES_PER_HOUR);
          endcase
        end
      end
      if (p >= 4'd2 && hist[1] == nrte_pkg::CH_COMMA && b == nrte_pkg::CH_COMMA) begin
        if (hist[2] == nrte_pkg::CH_V) fix = nrte_pkg::FIX_V;
        else if (hist[2] == nrte_pkg::CH_A && fix != nrte_pkg::FIX_V) fix = nrte_pkg::FIX_A;
      end
      if (p >= 4'd4) run_xor = run_xor ^ hist[0];
      hist[0] = hist[1];
      hist[1] = hist[2];
      hist[2] = b;
      if (npos < 4'd15) npos = npos + 4'd1;
    end
    if (is_last) begin
      has = 1'b1;
      if (halted) begin
        st = nrte_pkg::ST_END_MARK;
      end else if (!hdr_good || p < 4'd5) begin
        st = nrte_pkg::ST_NOT_RMC;
      end else if (time_bad || p < 4'd12) begin
        st = nrte_pkg::ST_BAD_TIME;
      end else begin
        hi = hex_of(hist[1]);
        lo = hex_of(hist[2]);
        if (hi < 0 || lo < 0 || hi * 16 + lo != int'(run_xor)) begin
          st = nrte_pkg::ST_BAD_CSUM;
        end else if (fix != nrte_pkg::FIX_A) begin
          st = nrte_pkg::ST_NOT_VALID;
        end else begin
          st = nrte_pkg::ST_ACCEPTED;
          t_hour = 5'((h_cand + offset_now) % 24);
          t_min = 6'(m_cand);
          t_sec = 6'(s_cand);
          t_valid = 1'b1;
        end
      end
      if (!halted) reset_sentence();
      r.status = st;
      r.have_time = t_valid;
      r.hour = t_hour;
      r.minute = t_min;
      r.second = t_sec;
    end
  endtask

  // ---- sentence building ----

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) tok_bytes.push_back(s[i]);
  endfunction

  function automatic void push_num2(int v);
    tok_bytes.push_back(nrte_pkg::CH_0 + 8'(v / 10));
    tok_bytes.push_back(nrte_pkg::CH_0 + 8'(v % 10));
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return nrte_pkg::CH_0 + 8'(n);
    return (lower ? nrte_pkg::CH_LA : nrte_pkg::CH_A) + 8'(n - 4'd10);
  endfunction

  function automatic void seal_checksum(cs_mode_t m);
    logic [7:0] x;
    x = 8'd0;
    for (int i = 1; i < tok_bytes.size(); i++) x = x ^ tok_bytes[i];
    if (m == CS_WRONG) x = x ^ 8'($urandom_range(1, 255));
    tok_bytes.push_back("*");
    tok_bytes.push_back(hex_char(x[7:4], m == CS_LOWER));
    tok_bytes.push_back(hex_char(x[3:0], m == CS_LOWER));
  endfunction

  function automatic void make_rmc();
    int         pick, f, nf, sel, n, idx;
    logic [7:0] c;
    tok_bytes.delete();
    push_text("$GPRMC,");
    pick = $urandom_range(0, 99);
    if (pick >= 80 && pick < 90) begin
      push_num2($urandom_range(0, 99));
      push_num2($urandom_range(0, 99));
      push_num2($urandom_range(0, 99));
    end else begin
      push_num2($urandom_range(0, 23));
      push_num2($urandom_range(0, 59));
      push_num2($urandom_range(0, 59));
    end
    if (pick >= 90) tok_bytes[$urandom_range(6, 12)] = 8'($urandom_range(0, 255));
    f = $urandom_range(0, 9);
    if (f <= 6) push_text(",A");
    else if (f == 7) push_text(",V");
    else if (f == 8) push_text($urandom_range(0, 1) ? ",A,V" : ",V,A");
    nf = $urandom_range(0, 4);
    for (int i = 0; i < nf; i++) begin
      sel = $urandom_range(0, 4);
      case (sel)
        0: push_text(",4807.038");
        1: push_text(",N");
        2: push_text(",");
        3: push_text(",AA");
        default: begin
          tok_bytes.push_back(nrte_pkg::CH_COMMA);
          n = $urandom_range(1, 3);
          for (int k = 0; k < n; k++) tok_bytes.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    if ($urandom_range(0, 9) < 7) push_text(",");
    sel = $urandom_range(0, 9);
    if (sel <= 3) seal_checksum(CS_UPPER);
    else if (sel <= 7) seal_checksum(CS_LOWER);
    else if (sel == 8) seal_checksum(CS_WRONG);
    else begin
      tok_bytes.push_back("*");
      tok_bytes.push_back(8'($urandom_range(0, 255)));
      tok_bytes.push_back(8'($urandom_range(0, 255)));
    end
    sel = $urandom_range(0, 19);
    if (sel <= 1) begin
      n = $urandom_range(1, tok_bytes.size() - 1);
      while (tok_bytes.size() > n) void'(tok_bytes.pop_back());
    end else if (sel == 2) begin
      idx = $urandom_range(0, 5);
      c = 8'($urandom_range(0, 255));
      if (idx == 0 && c == nrte_pkg::CH_E) c = nrte_pkg::CH_DOLLAR;
      tok_bytes[idx] = c;
    end
  endfunction

  function automatic void make_noise();
    int n;
    tok_bytes.delete();
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) tok_bytes.push_back(8'($urandom_range(0, 255)));
    if (tok_bytes[0] == nrte_pkg::CH_E) tok_bytes[0] = nrte_pkg::CH_DOLLAR;
  endfunction

  // ---- driving ----

  task automatic send_beat(input logic [7:0] b, input logic is_last);
    if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_value <= b;
    token_end <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_token(input bit use_lit, input nrte_pkg::result_t lit_val);
    bit                has;
    nrte_pkg::result_t pred;
    for (int i = 0; i < tok_bytes.size(); i++) begin
      send_beat(tok_bytes[i], i == tok_bytes.size() - 1);
      parse_byte(tok_bytes[i], i == tok_bytes.size() - 1, has, pred);
      if (has) status_due.push_back(use_lit ? lit_val : pred);
    end
    tokens_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_offset(input int v);
    cfg_we <= 1'b1;
    cfg_wdata <= 5'(v);
    offset_now = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic nrte_pkg::result_t lit_res(nrte_pkg::status_t st, bit ht, int h,
                                                int mi, int s);
    nrte_pkg::result_t r;
    r.status = st;
    r.have_time = ht;
    r.hour = 5'(h);
    r.minute = 6'(mi);
    r.second = 6'(s);
    return r;
  endfunction

  function automatic void add_row(string body, cs_mode_t m, bit lit,
                                  nrte_pkg::result_t want);
    row_t r;
    r.body = body;
    r.cs = m;
    r.cfg = -1;
    r.lit = lit;
    r.want = want;
    rows.push_back(r);
  endfunction

  function automatic void add_cfg(int v);
    row_t r;
    r.body = "";
    r.cs = CS_NONE;
    r.cfg = v;
    r.lit = 1'b0;
    r.want = '0;
    rows.push_back(r);
  endfunction

  // ---- receiver ----

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && sink_hold_pct > 0 && $urandom_range(0, 99) < sink_hold_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    nrte_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        note_error($sformatf("unexpected beat, status %0d", status));
      end else begin
        want = status_due.pop_front();
        beats_checked++;
        if (status == nrte_pkg::ST_ACCEPTED) fixes_taken++;
        if (status !== want.status)
          note_error($sformatf("status got %0d, want %0d", status, want.status));
        if (have_time !== want.have_time)
          note_error($sformatf("have_time got %0d, want %0d", have_time, want.have_time));
        if (out_hour !== want.hour)
          note_error($sformatf("hour got %0d, want %0d", out_hour, want.hour));
        if (out_minute !== want.minute)
          note_error($sformatf("minute got %0d, want %0d", out_minute, want.minute));
        if (out_second !== want.second)
          note_error($sformatf("second got %0d, want %0d", out_second, want.second));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               status_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---- main sequence ----

  initial begin
    int ph_tokens, ph_bytes;
    reset_sentence();
    t_hour = 5'd0;
    t_min = 6'd0;
    t_sec = 6'd0;
    t_valid = 1'b0;
    halted = 1'b0;
    offset_now = nrte_pkg::HOUR_OFFSET_RESET;

    // offset 8 from reset
    add_row("X", CS_NONE, 1, lit_res(nrte_pkg::ST_NOT_RMC, 0, 0, 0, 0));
    add_row("$GPRMC", CS_NONE, 1, lit_res(nrte_pkg::ST_BAD_TIME, 0, 0, 0, 0));
    add_row("$GPRMX,123456,A,", CS_UPPER, 1, lit_res(nrte_pkg::ST_NOT_RMC, 0, 0, 0, 0));
    add_row("$GPRMC,00000", CS_NONE, 1, lit_res(nrte_pkg::ST_BAD_TIME, 0, 0, 0, 0));
    add_row("$GPRMC,123456,A,", CS_UPPER, 1, lit_res(nrte_pkg::ST_ACCEPTED, 1, 20, 34, 56));
    add_row("$GPRMC,240000,A,", CS_UPPER, 1, lit_res(nrte_pkg::ST_BAD_TIME, 1, 20, 34, 56));
    add_row("$GPRMC,006000,A,", CS_UPPER, 1, lit_res(nrte_pkg::ST_BAD_TIME, 1, 20, 34, 56));
    add_row("$GPRMC,000060,A,", CS_UPPER, 1, lit_res(nrte_pkg::ST_BAD_TIME, 1, 20, 34, 56));
    add_row("$GPRMC;000000,A,", CS_UPPER, 1, lit_res(nrte_pkg::ST_BAD_TIME, 1, 20, 34, 56));
    add_row("$GPRMC,12a456,A,", CS_UPPER, 1, lit_res(nrte_pkg::ST_BAD_TIME, 1, 20, 34, 56));
    add_row("$GPRMC,000000,A,", CS_WRONG, 1, lit_res(nrte_pkg::ST_BAD_CSUM, 1, 20, 34, 56));
    add_row("$GPRMC,000000,A,*G0", CS_NONE, 1,
            lit_res(nrte_pkg::ST_BAD_CSUM, 1, 20, 34, 56));
    add_row("$GPRMC,000000,V,", CS_UPPER, 1, lit_res(nrte_pkg::ST_NOT_VALID, 1, 20, 34, 56));
    add_row("$GPRMC,000000,A,V,", CS_UPPER, 1,
            lit_res(nrte_pkg::ST_NOT_VALID, 1, 20, 34, 56));
    add_row("$GPRMC,000000,V,A,", CS_UPPER, 1,
            lit_res(nrte_pkg::ST_NOT_VALID, 1, 20, 34, 56));
    add_row("$GPRMC,000000,AV,", CS_UPPER, 1,
            lit_res(nrte_pkg::ST_NOT_VALID, 1, 20, 34, 56));
    add_row("$GPRMC,235959,A,", CS_UPPER, 1, lit_res(nrte_pkg::ST_ACCEPTED, 1, 7, 59, 59));
    add_row("$GPRMC,010203,A,4807.038,N,", CS_LOWER, 0, '0);
    add_row("$GPRMC,000000", CS_NONE, 0, '0);
    add_cfg(0);
    add_row("$GPRMC,000000,A,", CS_UPPER, 1, lit_res(nrte_pkg::ST_ACCEPTED, 1, 0, 0, 0));
    add_cfg(23);
    add_row("$GPRMC,235959,A,", CS_UPPER, 1, lit_res(nrte_pkg::ST_ACCEPTED, 1, 22, 59, 59));
    add_cfg(31);
    add_row("$GPRMC,235959,A,", CS_LOWER, 1, lit_res(nrte_pkg::ST_ACCEPTED, 1, 6, 59, 59));
    add_row("$GPRMC,130000,A,", CS_UPPER, 0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    src_gap_pct = 20;
    sink_hold_pct = 20;
    foreach (rows[i]) begin
      if (rows[i].body.len() == 0) begin
        settle();
        set_offset(rows[i].cfg);
      end else begin
        tok_bytes.delete();
        push_text(rows[i].body);
        if (rows[i].cs != CS_NONE) seal_checksum(rows[i].cs);
        send_token(rows[i].lit, rows[i].want);
      end
    end

    // random sentences; each phase starts from an idle block with a new offset
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      set_offset($urandom_range(0, 31));
      case (ph)
        0: begin src_gap_pct = 25; sink_hold_pct = 25; end
        1: begin src_gap_pct = 0;  sink_hold_pct = 40; end
        2: begin src_gap_pct = 40; sink_hold_pct = 0;  end
        default: begin src_gap_pct = 0; sink_hold_pct = 0; end
      endcase
      ph_tokens = 0;
      ph_bytes = bytes_sent;
      while (ph_tokens < 2 || bytes_sent - ph_bytes < 24) begin
        if ($urandom_range(0, 3) != 0) make_rmc();
        else make_noise();
        send_token(1'b0, '0);
        ph_tokens++;
      end
    end

    // stop marker: everything after it reports the end status
    settle();
    tok_bytes.delete();
    push_text("EOF");
    send_token(1'b0, '0);
    tok_bytes.delete();
    push_text("$GPRMC,120000,A,");
    seal_checksum(CS_UPPER);
    send_token(1'b0, '0);
    make_noise();
    send_token(1'b0, '0);
    settle();
    repeat (8) @(posedge clk);

    if (status_due.size() != 0)
      note_error($sformatf("%0d status beats never arrived", status_due.size()));
    $display("Sent %0d sentences (%0d bytes); checked %0d status beats, %0d of them fixes.",
             tokens_sent, bytes_sent, beats_checked, fixes_taken);
    $display("Covered all reject codes, offsets 0/8/23/31 plus random, gaps, stalls, stop.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
